/* hw/rtl/gptc_pkg.sv */
package gptc_pkg;

	localparam int unsigned NUM_COMPARE_DEF = 3;
	localparam int unsigned MAX_COMPARE     = 3;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned OFFSET_W = 14;
	localparam int unsigned RATIO_W  = 5;
	localparam int unsigned PRE_W    = 12;
	localparam int unsigned PHASE_W  = 16;
	localparam int unsigned STAT_W   = 6;
	localparam int unsigned DIV_W    = RATIO_W + PRE_W + 1;

	localparam logic [DATA_W-1:0]   CR_KEEP    = 32'h0000_03FF;
	localparam logic [DATA_W-1:0]   CR_NOSTORE = 32'hE000_8000;
	localparam int unsigned         CR_EN_BIT    = 0;
	localparam int unsigned         CR_ENMOD_BIT = 1;
	localparam int unsigned         CR_CLKSRC_LO = 6;
	localparam int unsigned         CR_FRR_BIT   = 9;
	localparam int unsigned         CR_SWR_BIT   = 15;
	localparam logic [2:0]          CLKSRC_PERIPH = 3'd1;
	localparam int unsigned         ST_ROV_BIT   = 5;
	localparam logic [OFFSET_W-1:0] REG_END      = 14'h0028;
	localparam logic [RATIO_W-1:0]  RATIO_RESET  = 5'd1;
	localparam logic [RATIO_W-1:0]  RATIO_MAX    = 5'd16;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_IDLE  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		REG_CONTROL  = 4'd0,
		REG_PRESCALE = 4'd1,
		REG_STATUS   = 4'd2,
		REG_IRQ_EN   = 4'd3,
		REG_CMP1     = 4'd4,
		REG_CMP2     = 4'd5,
		REG_CMP3     = 4'd6,
		REG_CAPT1    = 4'd7,
		REG_CAPT2    = 4'd8,
		REG_COUNT    = 4'd9
	} reg_idx_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq_line;
		logic              access_error;
		logic              clock_source_fault;
	} rsp_t;

endpackage

/* hw/rtl/gptc_if.sv */
interface gptc_req_if import gptc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic [OFFSET_W-1:0] byte_offset;
	logic [DATA_W-1:0]   write_data;

	modport source (output valid, output func, output byte_offset, output write_data,
		input ready);
	modport sink (input valid, input func, input byte_offset, input write_data,
		output ready);
endinterface

interface gptc_rsp_if import gptc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              irq_line;
	logic              access_error;
	logic              clock_source_fault;

	modport source (output valid, output read_data, output irq_line, output access_error,
		output clock_source_fault, input ready);
	modport sink (input valid, input read_data, input irq_line, input access_error,
		input clock_source_fault, output ready);
endinterface

/* hw/rtl/general_purpose_timer_compare.sv */
// General purpose timer with output compare.
// req channel: one request per cpu cycle unless a response is stalled; func
//   selects tick, read, write or idle at byte_offset (ten 32-bit registers).
// rsp channel: one response per request with read_data, irq_line,
//   access_error and clock_source_fault.
// cfg_we/cfg_wdata: writes clock_ratio, the cpu ticks per peripheral clock.
// The response is registered and becomes valid in the cycle after the
//   request is accepted; all state updates for a request are made in the
//   cycle it is accepted, between the request port and the response
//   register.
// When the receiver stalls, the response register holds its value and
//   req.ready stays low until it is taken; a new request is accepted in the
//   same cycle the held response is taken.
// At reset all registers but the response data take their reset values
//   (compare values all ones, clock_ratio 1) and no response is pending.
module general_purpose_timer_compare import gptc_pkg::*; #(
	parameter int unsigned NUM_COMPARE = NUM_COMPARE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [RATIO_W-1:0] cfg_wdata,
	gptc_req_if.sink           req,
	gptc_rsp_if.source         rsp
);

	logic [RATIO_W-1:0]  ratio_q;
	logic [DATA_W-1:0]   ctrl_q, ctrl_d;
	logic [PRE_W-1:0]    pre_q, pre_d;
	logic [STAT_W-1:0]   st_q, st_d;
	logic [STAT_W-1:0]   ien_q, ien_d;
	logic [DATA_W-1:0]   cmp_q [NUM_COMPARE];
	logic [DATA_W-1:0]   cmp_d [NUM_COMPARE];
	logic [DATA_W-1:0]   cnt_q, cnt_d;
	logic [PHASE_W-1:0]  phase_q, phase_d;
	logic                rsp_valid_q;
	rsp_t                rsp_q, rsp_d;

	logic                accept;
	logic [3:0]          idx;
	logic                bad;
	logic                counting;
	logic [RATIO_W-1:0]  ratio_sat;
	logic [DIV_W-1:0]    div;
	logic [PHASE_W-1:0]  phase_inc;
	logic [DATA_W-1:0]   cnt_inc;
	logic [NUM_COMPARE-1:0] match;
	logic [DATA_W-1:0]   ctrl_new;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign idx      = req.byte_offset[5:2];
	assign bad      = (req.byte_offset[1:0] != 2'd0) || (req.byte_offset >= REG_END);
	assign counting = ctrl_q[CR_EN_BIT] && (ctrl_q[CR_CLKSRC_LO +: 3] == CLKSRC_PERIPH);

	assign ratio_sat = (ratio_q == '0) ? RATIO_RESET :
		((ratio_q > RATIO_MAX) ? RATIO_MAX : ratio_q);
	assign div       = DIV_W'(ratio_sat) * (DIV_W'(pre_q) + DIV_W'(1));
	assign phase_inc = phase_q + PHASE_W'(1);
	assign cnt_inc   = cnt_q + DATA_W'(1);
	assign ctrl_new  = req.write_data & ~CR_NOSTORE;

	always_comb begin
		for (int i = 0; i < NUM_COMPARE; i++) begin
			match[i] = (cmp_q[i] == cnt_inc);
		end
	end

	always_comb begin
		ctrl_d  = ctrl_q;
		pre_d   = pre_q;
		st_d    = st_q;
		ien_d   = ien_q;
		cmp_d   = cmp_q;
		cnt_d   = cnt_q;
		phase_d = phase_q;
		rsp_d   = '0;

		if (accept) begin
			case (func_t'(req.func))
				FUNC_TICK: begin
					if (counting) begin
						if ((DIV_W'(phase_inc) < div) && (phase_inc != '0)) begin
							phase_d = phase_inc;
						end else begin
							phase_d = '0;
							cnt_d   = cnt_inc;
							if (cnt_inc == '0) begin
								st_d[ST_ROV_BIT] = 1'b1;
							end
							for (int i = 0; i < NUM_COMPARE; i++) begin
								if (match[i]) begin
									st_d[i] = 1'b1;
								end
							end
							if (match[0] && !ctrl_q[CR_FRR_BIT]) begin
								cnt_d = '0;
							end
						end
					end
				end
				FUNC_READ: begin
					if (bad) begin
						rsp_d.access_error = 1'b1;
					end else begin
						case (idx)
							REG_CONTROL:  rsp_d.read_data = ctrl_q;
							REG_PRESCALE: rsp_d.read_data = DATA_W'(pre_q);
							REG_STATUS:   rsp_d.read_data = DATA_W'(st_q);
							REG_IRQ_EN:   rsp_d.read_data = DATA_W'(ien_q);
							REG_CMP1, REG_CMP2, REG_CMP3: begin
								rsp_d.read_data = '1;
								for (int i = 0; i < NUM_COMPARE; i++) begin
									if (idx == 4'(int'(REG_CMP1) + i)) begin
										rsp_d.read_data = cmp_q[i];
									end
								end
							end
							REG_COUNT:    rsp_d.read_data = cnt_q;
							default:      rsp_d.read_data = '0;
						endcase
					end
				end
				FUNC_WRITE: begin
					if (bad) begin
						rsp_d.access_error = 1'b1;
					end else begin
						case (idx)
							REG_CONTROL: begin
								if (req.write_data[CR_SWR_BIT]) begin
									ctrl_d  = ctrl_q & CR_KEEP;
									pre_d   = '0;
									st_d    = '0;
									ien_d   = '0;
									for (int i = 0; i < NUM_COMPARE; i++) begin
										cmp_d[i] = '1;
									end
									cnt_d   = '0;
									phase_d = '0;
								end else begin
									ctrl_d = ctrl_new;
									if (!ctrl_q[CR_EN_BIT] && ctrl_new[CR_EN_BIT]) begin
										if (ctrl_new[CR_ENMOD_BIT]) begin
											cnt_d = '0;
										end
										phase_d = '0;
									end
									if (ctrl_q[CR_CLKSRC_LO +: 3] != ctrl_new[CR_CLKSRC_LO +: 3]) begin
										phase_d = '0;
									end
									rsp_d.clock_source_fault = (ctrl_new[CR_CLKSRC_LO +: 3] > CLKSRC_PERIPH);
								end
							end
							REG_PRESCALE: begin
								pre_d   = req.write_data[PRE_W-1:0];
								phase_d = '0;
							end
							REG_STATUS: st_d = st_q & ~req.write_data[STAT_W-1:0];
							REG_IRQ_EN: ien_d = req.write_data[STAT_W-1:0];
							REG_CMP1, REG_CMP2, REG_CMP3: begin
								for (int i = 0; i < NUM_COMPARE; i++) begin
									if (idx == 4'(int'(REG_CMP1) + i)) begin
										cmp_d[i] = req.write_data;
									end
								end
								if ((idx == REG_CMP1) && !ctrl_q[CR_FRR_BIT] && ctrl_q[CR_EN_BIT]) begin
									cnt_d   = '0;
									phase_d = '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end

		rsp_d.irq_line = |(st_d & ien_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q     <= RATIO_RESET;
			ctrl_q      <= '0;
			pre_q       <= '0;
			st_q        <= '0;
			ien_q       <= '0;
			for (int i = 0; i < NUM_COMPARE; i++) begin
				cmp_q[i] <= '1;
			end
			cnt_q       <= '0;
			phase_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ratio_q <= cfg_wdata;
			end
			ctrl_q  <= ctrl_d;
			pre_q   <= pre_d;
			st_q    <= st_d;
			ien_q   <= ien_d;
			cmp_q   <= cmp_d;
			cnt_q   <= cnt_d;
			phase_q <= phase_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the response while the receiver stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.read_data          = rsp_q.read_data;
	assign rsp.irq_line           = rsp_q.irq_line;
	assign rsp.access_error       = rsp_q.access_error;
	assign rsp.clock_source_fault = rsp_q.clock_source_fault;

endmodule

/* dv/tb_general_purpose_timer_compare.sv */
`timescale 1ns / 100ps

module tb_general_purpose_timer_compare;
	import gptc_pkg::*;

	localparam int NUM_CMP   = NUM_COMPARE_DEF;
	localparam int MAX_SHOWN = 10;
	localparam int LAST_REG  = int'(REG_COUNT);

	typedef struct {
		func_t               fn;
		logic [OFFSET_W-1:0] off;
		logic [DATA_W-1:0]   data;
	} bus_req_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [RATIO_W-1:0] cfg_wdata;
	logic               steady;

	gptc_req_if req ();
	gptc_rsp_if rsp ();

	general_purpose_timer_compare #(.NUM_COMPARE(NUM_CMP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	logic [RATIO_W-1:0] t_ratio;
	logic [DATA_W-1:0]  t_ctrl;
	logic [PRE_W-1:0]   t_pre;
	logic [STAT_W-1:0]  t_stat;
	logic [STAT_W-1:0]  t_ien;
	logic [DATA_W-1:0]  t_cmp [MAX_COMPARE];
	logic [DATA_W-1:0]  t_cnt;
	logic [PHASE_W-1:0] t_phase;

	bus_req_t req_pend_q[$];
	rsp_t     rsp_due_q[$];
	bus_req_t in_flight;
	rsp_t     got;
	rsp_t     want;

	int n_pushed;
	int n_items;
	int n_rsp;
	int n_checked;
	int n_bad;
	int n_irq;
	int n_err;
	int n_fault;
	int n_settings;

	function automatic bit chan_live(int n);
		return n >= 0 && n < NUM_CMP && n < MAX_COMPARE;
	endfunction

	function automatic int unsigned ratio_eff();
		if (t_ratio == '0)
			return 1;
		return (t_ratio > RATIO_MAX) ? int'(RATIO_MAX) : int'(t_ratio);
	endfunction

	function automatic void clear_regs();
		t_pre   = '0;
		t_stat  = '0;
		t_ien   = '0;
		for (int n = 0; n < MAX_COMPARE; n++)
			t_cmp[n] = '1;
		t_cnt   = '0;
		t_phase = '0;
	endfunction

	function automatic void timer_tick();
		int unsigned period;
		if (!(t_ctrl[CR_EN_BIT] && t_ctrl[CR_CLKSRC_LO +: 3] == CLKSRC_PERIPH))
			return;
		period  = ratio_eff() * (int'(t_pre) + 1);
		t_phase = t_phase + 1'b1;
		if (t_phase < period && t_phase != '0)
			return;
		t_phase = '0;
		t_cnt   = t_cnt + 1'b1;
		if (t_cnt == '0)
			t_stat[ST_ROV_BIT] = 1'b1;
		for (int n = 0; n < MAX_COMPARE; n++)
			if (chan_live(n) && t_cmp[n] == t_cnt)
				t_stat[n] = 1'b1;
		if (chan_live(0) && t_cmp[0] == t_cnt && !t_ctrl[CR_FRR_BIT])
			t_cnt = '0;
	endfunction

	function automatic logic [DATA_W-1:0] timer_read(reg_idx_t r);
		int n;
		n = int'(r) - int'(REG_CMP1);
		case (r)
			REG_CONTROL:  return t_ctrl;
			REG_PRESCALE: return DATA_W'(t_pre);
			REG_STATUS:   return DATA_W'(t_stat);
			REG_IRQ_EN:   return DATA_W'(t_ien);
			REG_CMP1, REG_CMP2, REG_CMP3: return chan_live(n) ? t_cmp[n] : '1;
			REG_COUNT:    return t_cnt;
			default:      return '0;
		endcase
	endfunction

	function automatic bit timer_write_ctrl(logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] prev;
		logic [DATA_W-1:0] kept;
		prev = t_ctrl;
		kept = v & ~CR_NOSTORE;
		if (v[CR_SWR_BIT]) begin
			t_ctrl = prev & CR_KEEP;
			clear_regs();
			return 1'b0;
		end
		t_ctrl = kept;
		if (!prev[CR_EN_BIT] && kept[CR_EN_BIT]) begin
			if (kept[CR_ENMOD_BIT])
				t_cnt = '0;
			t_phase = '0;
		end
		if (prev[CR_CLKSRC_LO +: 3] != kept[CR_CLKSRC_LO +: 3])
			t_phase = '0;
		return kept[CR_CLKSRC_LO +: 3] > CLKSRC_PERIPH;
	endfunction

	function automatic bit timer_write(reg_idx_t r, logic [DATA_W-1:0] v);
		int n;
		n = int'(r) - int'(REG_CMP1);
		case (r)
			REG_CONTROL: return timer_write_ctrl(v);
			REG_PRESCALE: begin
				t_pre   = v[PRE_W-1:0];
				t_phase = '0;
			end
			REG_STATUS: t_stat = t_stat & ~v[STAT_W-1:0];
			REG_IRQ_EN: t_ien = v[STAT_W-1:0];
			REG_CMP1, REG_CMP2, REG_CMP3: begin
				if (chan_live(n)) begin
					t_cmp[n] = v;
					if (r == REG_CMP1 && !t_ctrl[CR_FRR_BIT] && t_ctrl[CR_EN_BIT]) begin
						t_cnt   = '0;
						t_phase = '0;
					end
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic rsp_t timer_predict(bus_req_t it);
		rsp_t o;
		o = '0;
		if (it.fn == FUNC_TICK) begin
			timer_tick();
		end else if (it.fn == FUNC_READ || it.fn == FUNC_WRITE) begin
			if (it.off[1:0] != 2'b00 || it.off >= REG_END)
				o.access_error = 1'b1;
			else if (it.fn == FUNC_READ)
				o.read_data = timer_read(reg_idx_t'(it.off[5:2]));
			else
				o.clock_source_fault = timer_write(reg_idx_t'(it.off[5:2]), it.data);
		end
		o.irq_line = |(t_stat & t_ien);
		return o;
	endfunction

	function automatic logic [OFFSET_W-1:0] reg_addr(reg_idx_t r);
		return OFFSET_W'({r, 2'b00});
	endfunction

	function automatic logic [DATA_W-1:0] ctrl_word(bit en, bit enmod, bit frr, logic [2:0] src,
		logic [DATA_W-1:0] rest);
		logic [DATA_W-1:0] v;
		v = rest;
		v[CR_EN_BIT]          = en;
		v[CR_ENMOD_BIT]       = enmod;
		v[CR_FRR_BIT]         = frr;
		v[CR_CLKSRC_LO +: 3]  = src;
		v[CR_SWR_BIT]         = 1'b0;
		return v;
	endfunction

	task automatic put(func_t fn, logic [OFFSET_W-1:0] off, logic [DATA_W-1:0] data);
		bus_req_t it;
		it.fn   = fn;
		it.off  = off;
		it.data = data;
		req_pend_q.push_back(it);
		n_pushed++;
		if (fn != FUNC_IDLE)
			n_items++;
	endtask

	task automatic wr(reg_idx_t r, logic [DATA_W-1:0] data);
		put(FUNC_WRITE, reg_addr(r), data);
	endtask

	task automatic rd(reg_idx_t r);
		put(FUNC_READ, reg_addr(r), $urandom);
	endtask

	task automatic tick();
		put(FUNC_TICK, OFFSET_W'($urandom), $urandom);
	endtask

	task automatic wait_idle();
		while (n_rsp < n_pushed)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_ratio(logic [RATIO_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		t_ratio = v;
		n_settings++;
	endtask

	task automatic directed();
		rd(REG_CONTROL);
		rd(REG_CMP1);
		wr(REG_PRESCALE, '1);
		rd(REG_PRESCALE);
		wr(REG_PRESCALE, '0);
		wr(REG_IRQ_EN, '1);
		wr(REG_CMP1, 32'd3);
		wr(REG_CMP2, 32'd2);
		wr(REG_CMP3, 32'd5);
		wr(REG_CONTROL, ctrl_word(1'b1, 1'b1, 1'b0, CLKSRC_PERIPH, '0));
		repeat (4) tick();
		rd(REG_STATUS);
		wr(REG_CMP1, 32'd4);
		rd(REG_COUNT);
		wr(REG_STATUS, '1);
		wr(REG_CONTROL, ctrl_word(1'b1, 1'b0, 1'b1, 3'd7, 32'hE000_0000));
		tick();
		rd(REG_CAPT2);
		put(FUNC_READ, OFFSET_W'(2), '0);
		put(FUNC_WRITE, '1, '1);
		put(FUNC_READ, REG_END, '0);
		wr(REG_COUNT, '1);
		put(FUNC_IDLE, reg_addr(REG_CONTROL), '1);
		wr(REG_CONTROL, '1);
		rd(REG_CONTROL);
	endtask

	task automatic timer_session();
		logic [DATA_W-1:0] v;
		logic [2:0]        src;
		bit                fresh;
		int unsigned       nt;
		if ($urandom_range(7) == 0)
			wr(REG_CONTROL, $urandom | (32'd1 << CR_SWR_BIT));
		v = $urandom;
		case ($urandom_range(9))
			0:       ;
			1, 2:    v[PRE_W-1:0] = PRE_W'($urandom_range(7));
			default: v = $urandom_range(2);
		endcase
		wr(REG_PRESCALE, v);
		wr(REG_IRQ_EN, $urandom);
		for (int n = 0; n < MAX_COMPARE; n++) begin
			v = ($urandom_range(5) == 0) ? $urandom : $urandom_range(1, 12);
			wr(reg_idx_t'(int'(REG_CMP1) + n), v);
		end
		fresh = $urandom_range(3) != 0;
		if (fresh)
			wr(REG_CONTROL, ctrl_word(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)),
				CLKSRC_PERIPH, $urandom));
		src = ($urandom_range(7) == 0) ? 3'($urandom) : CLKSRC_PERIPH;
		wr(REG_CONTROL, ctrl_word($urandom_range(9) != 0, fresh || $urandom_range(1),
			1'($urandom_range(1)), src, $urandom));
		nt = $urandom_range(4, 20) + ratio_eff() * $urandom_range(1, 4);
		repeat (nt) begin
			case ($urandom_range(11))
				0: rd(reg_idx_t'($urandom_range(LAST_REG)));
				1: begin
					if ($urandom_range(3) == 0)
						wr(REG_CMP1, $urandom_range(1, 12));
					else
						rd(REG_COUNT);
				end
				default: tick();
			endcase
		end
		rd(REG_STATUS);
		rd(REG_COUNT);
		wr(REG_STATUS, $urandom);
	endtask

	task automatic noise_burst();
		logic [OFFSET_W-1:0] off;
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(2))
				0:       off = OFFSET_W'($urandom);
				1:       off = (OFFSET_W'($urandom_range(LAST_REG)) << 2) |
					OFFSET_W'($urandom_range(3));
				default: off = reg_addr(reg_idx_t'($urandom_range(LAST_REG)));
			endcase
			put(func_t'($urandom_range(3)), off, $urandom);
		end
	endtask

	task automatic random_phase(int target);
		int stop;
		stop = n_items + target;
		while (n_items < stop) begin
			if ($urandom_range(9) < 8)
				timer_session();
			else
				noise_burst();
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				rsp_due_q.push_back(timer_predict(in_flight));
			if (!req.valid || req.ready) begin
				if (req_pend_q.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
					in_flight = req_pend_q.pop_front();
					req.valid       <= 1'b1;
					req.func        <= in_flight.fn;
					req.byte_offset <= in_flight.off;
					req.write_data  <= in_flight.data;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				n_rsp++;
				got.read_data          = rsp.read_data;
				got.irq_line           = rsp.irq_line;
				got.access_error       = rsp.access_error;
				got.clock_source_fault = rsp.clock_source_fault;
				if (rsp_due_q.size() == 0) begin
					n_bad++;
					if (n_bad <= MAX_SHOWN)
						$display("unexpected response: rd=%h irq=%b err=%b fault=%b",
							got.read_data, got.irq_line, got.access_error,
							got.clock_source_fault);
				end else begin
					want = rsp_due_q.pop_front();
					n_checked++;
					if (got.read_data !== want.read_data || got.irq_line !== want.irq_line ||
						got.access_error !== want.access_error ||
						got.clock_source_fault !== want.clock_source_fault) begin
						n_bad++;
						if (n_bad <= MAX_SHOWN)
							$display("mismatch on response %0d: expected rd=%h irq=%b err=%b fault=%b, got rd=%h irq=%b err=%b fault=%b",
								n_checked, want.read_data, want.irq_line,
								want.access_error, want.clock_source_fault,
								got.read_data, got.irq_line, got.access_error,
								got.clock_source_fault);
					end
					n_irq   += got.irq_line;
					n_err   += got.access_error;
					n_fault += got.clock_source_fault;
				end
			end
			rsp.ready <= steady || $urandom_range(99) >= 8;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = RATIO_RESET;
		steady          = 1'b0;
		req.valid       = 1'b0;
		req.func        = FUNC_IDLE;
		req.byte_offset = '0;
		req.write_data  = '0;
		rsp.ready       = 1'b0;
		n_pushed        = 0;
		n_items         = 0;
		n_rsp           = 0;
		n_checked       = 0;
		n_bad           = 0;
		n_irq           = 0;
		n_err           = 0;
		n_fault         = 0;
		n_settings      = 1;
		t_ratio         = RATIO_RESET;
		t_ctrl          = '0;
		clear_regs();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		directed();
		wait_idle();
		random_phase(30);
		wait_idle();
		set_ratio(RATIO_MAX);
		random_phase(100);
		wait_idle();
		set_ratio('0);
		steady <= 1'b1;
		random_phase(100);
		wait_idle();
		steady <= 1'b0;
		set_ratio('1);
		random_phase(100);
		wait_idle();
		set_ratio(RATIO_W'(3));
		random_phase(100);
		wait_idle();
		set_ratio(RATIO_W'($urandom_range(1, 16)));
		random_phase(80);
		wait_idle();
		$display("checked %0d responses to %0d requests over %0d clock ratio settings",
			n_checked, n_pushed, n_settings);
		$display("irq high %0d, access errors %0d, clock source faults %0d, mismatches %0d",
			n_irq, n_err, n_fault, n_bad);
		if (n_bad == 0 && rsp_due_q.size() == 0) begin
			$display("tb_general_purpose_timer_compare: PASS");
		end else begin
			if (rsp_due_q.size() != 0)
				$display("%0d responses never arrived", rsp_due_q.size());
			$display("tb_general_purpose_timer_compare: FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d of %0d responses received", n_rsp, n_pushed);
		$display("tb_general_purpose_timer_compare: FAIL");
		$finish;
	end

endmodule
